// ===== sv/mau_pkg.sv =====
package mau_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 31;
    localparam int unsigned MODULUS_RESET   = 1234577;

    // action codes
    typedef enum logic [2:0] {
        ACT_NEG = 3'd0,
        ACT_ADD = 3'd1,
        ACT_SUB = 3'd2,
        ACT_MUL = 3'd3,
        ACT_DIV = 3'd4,
        ACT_REM = 3'd5,
        ACT_POW = 3'd6,
        ACT_NOP = 3'd7
    } t_action;

    // shared divider operations
    typedef enum logic [1:0] {
        OP_MOD,
        OP_DIVMOD,
        OP_MULMOD
    } t_alu_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_DISPATCH,
        ST_PEXP,
        ST_EU_DIV,
        ST_EU_UPD,
        ST_EU_TFIX,
        ST_DIV_MUL,
        ST_REM,
        ST_PW_TEST,
        ST_PW_MUL,
        ST_PW_SQR,
        ST_SIMPLE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  action;
        logic [30:0] operand_a;
        logic [30:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [30:0] value;
        logic        error;
    } t_rsp;

endpackage

// ===== sv/modular_arithmetic_unit.sv =====
// Sequence, accept edge to result strobe: add, subtract, negate, unknown and a
// zero divisor finish after two operand reductions in the shared divider.
// Multiply and remainder add one divider pass. Divide adds a divide and a
// mulmod per Euclid step; power adds up to two mulmods per exponent bit.
// One request at a time: busy stays high until the result strobe.
// Receiver cannot stall. Synchronous active-low reset restores modulus 1234577.
module modular_arithmetic_unit
    import mau_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    input  logic  i_cfg_we,
    input  logic [30:0] i_cfg_data,
    output logic  o_valid,
    output t_rsp  o_rsp
);

    localparam int unsigned W = VALUE_WIDTH;

    t_state r_st, n_st;
    logic [W-1:0] r_mod;
    logic [W-1:0] w_m;
    logic [2:0]   r_act, n_act;
    logic [W-1:0] r_a, n_a, r_b, n_b;
    // Euclid: r0, r1 and t0,t1 modulo m (t tracked mod m, always reduced)
    logic [W-1:0] r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_e, n_e;
    logic [W-1:0] r_val, n_val;
    logic         r_err, n_err;
    logic         r_ovld, n_ovld;
    logic         r_go, n_go;
    t_alu_op      r_op, n_op;
    logic [W-1:0] r_x, n_x, r_y, n_y, r_d, n_d;
    logic         w_done;
    logic [W-1:0] w_rem, w_quo;
    logic [W:0]   w_sum;

    // effective modulus: below 2 acts as 2
    assign w_m = (r_mod < W'(2)) ? W'(2) : r_mod;

    mau_divu #(.W(W)) u_divu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_go),
        .i_op   (r_op),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_d    (r_d),
        .o_done (w_done),
        .o_rem  (w_rem),
        .o_quo  (w_quo)
    );

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(MODULUS_RESET);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data[W-1:0];
        end
    end

    always_comb begin
        n_st   = r_st;
        n_act  = r_act;
        n_a    = r_a;
        n_b    = r_b;
        n_r0   = r_r0;
        n_r1   = r_r1;
        n_t0   = r_t0;
        n_t1   = r_t1;
        n_acc  = r_acc;
        n_e    = r_e;
        n_val  = r_val;
        n_err  = r_err;
        n_ovld = 1'b0;
        n_go   = 1'b0;
        n_op   = r_op;
        n_x    = r_x;
        n_y    = r_y;
        n_d    = r_d;
        w_sum  = '0;
        unique case (r_st)
            ST_IDLE: begin
                if (start) begin
                    n_act = i_req.action;
                    n_b   = i_req.operand_b[W-1:0];
                    n_op  = OP_MOD;
                    n_x   = i_req.operand_a[W-1:0];
                    n_d   = w_m;
                    n_go  = 1'b1;
                    n_err = 1'b0;
                    n_val = '0;
                    n_st  = ST_RED_A;
                end
            end
            ST_RED_A: begin
                if (w_done) begin
                    n_a  = w_rem;
                    n_op = OP_MOD;
                    n_x  = r_b;
                    n_d  = w_m;
                    n_go = 1'b1;
                    n_st = ST_RED_B;
                end
            end
            ST_RED_B: begin
                if (w_done) begin
                    n_b  = w_rem;
                    n_st = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (r_act)
                    ACT_MUL: begin
                        n_op = OP_MULMOD;
                        n_x  = r_a;
                        n_y  = r_b;
                        n_d  = w_m;
                        n_go = 1'b1;
                        n_st = ST_SIMPLE;
                    end
                    ACT_DIV: begin
                        if (r_b == '0) begin
                            n_err = 1'b1;
                            n_st  = ST_DONE;
                        end else begin
                            n_r0 = w_m;
                            n_r1 = r_b;
                            n_t0 = '0;
                            n_t1 = W'(1);
                            n_op = OP_DIVMOD;
                            n_x  = w_m;
                            n_d  = r_b;
                            n_go = 1'b1;
                            n_st = ST_EU_DIV;
                        end
                    end
                    ACT_REM: begin
                        if (r_b == '0) begin
                            n_err = 1'b1;
                            n_st  = ST_DONE;
                        end else begin
                            n_op = OP_MOD;
                            n_x  = r_a;
                            n_d  = r_b;
                            n_go = 1'b1;
                            n_st = ST_REM;
                        end
                    end
                    ACT_POW: begin
                        // exponent mod (m-1); m-1 = 1 gives zero exponent
                        n_op = OP_MOD;
                        n_x  = r_b;
                        n_d  = w_m - W'(1);
                        n_go = 1'b1;
                        n_st = ST_PEXP;
                    end
                    ACT_NEG: begin
                        n_val = (r_a == '0) ? '0 : w_m - r_a;
                        n_st  = ST_DONE;
                    end
                    ACT_ADD: begin
                        w_sum = {1'b0, r_a} + {1'b0, r_b};
                        if (w_sum >= {1'b0, w_m}) w_sum = w_sum - {1'b0, w_m};
                        n_val = w_sum[W-1:0];
                        n_st  = ST_DONE;
                    end
                    ACT_SUB: begin
                        n_val = (r_a >= r_b) ? r_a - r_b : r_a + (w_m - r_b);
                        n_st  = ST_DONE;
                    end
                    default: begin
                        n_st = ST_DONE;
                    end
                endcase
            end
            ST_EU_DIV: begin
                // w_quo = r0 / r1, w_rem = r0 mod r1; q*t1 mod m next
                if (w_done) begin
                    n_r0 = r_r1;
                    n_r1 = w_rem;
                    n_op = OP_MULMOD;
                    n_x  = r_t1;
                    n_y  = w_quo;
                    n_d  = w_m;
                    n_go = 1'b1;
                    n_st = ST_EU_UPD;
                end
            end
            ST_EU_UPD: begin
                if (w_done) begin
                    // t_new = t0 - q*t1 mod m
                    n_t0 = r_t1;
                    n_t1 = (r_t0 >= w_rem) ? r_t0 - w_rem : r_t0 + (w_m - w_rem);
                    n_st = ST_EU_TFIX;
                end
            end
            ST_EU_TFIX: begin
                if (r_r1 == '0) begin
                    if (r_r0 != W'(1) || r_t0 == '0) begin
                        n_err = 1'b1;
                        n_st  = ST_DONE;
                    end else begin
                        n_op = OP_MULMOD;
                        n_x  = r_a;
                        n_y  = r_t0;
                        n_d  = w_m;
                        n_go = 1'b1;
                        n_st = ST_DIV_MUL;
                    end
                end else begin
                    n_op = OP_DIVMOD;
                    n_x  = r_r0;
                    n_d  = r_r1;
                    n_go = 1'b1;
                    n_st = ST_EU_DIV;
                end
            end
            ST_DIV_MUL, ST_SIMPLE, ST_REM: begin
                if (w_done) begin
                    n_val = w_rem;
                    n_st  = ST_DONE;
                end
            end
            ST_PEXP: begin
                if (w_done) begin
                    n_e   = w_rem;
                    n_acc = W'(1);
                    if (w_rem == '0) begin
                        n_val = W'(1);
                        n_st  = ST_DONE;
                    end else begin
                        n_st = ST_PW_TEST;
                    end
                end
            end
            ST_PW_TEST: begin
                if (r_e == '0) begin
                    n_val = r_acc;
                    n_st  = ST_DONE;
                end else if (r_e[0]) begin
                    n_op = OP_MULMOD;
                    n_x  = r_a;
                    n_y  = r_acc;
                    n_d  = w_m;
                    n_go = 1'b1;
                    n_st = ST_PW_MUL;
                end else begin
                    n_op = OP_MULMOD;
                    n_x  = r_a;
                    n_y  = r_a;
                    n_d  = w_m;
                    n_go = 1'b1;
                    n_st = ST_PW_SQR;
                end
            end
            ST_PW_MUL: begin
                if (w_done) begin
                    n_acc = w_rem;
                    n_op  = OP_MULMOD;
                    n_x   = r_a;
                    n_y   = r_a;
                    n_d   = w_m;
                    n_go  = 1'b1;
                    n_st  = ST_PW_SQR;
                end
            end
            ST_PW_SQR: begin
                if (w_done) begin
                    n_a  = w_rem;
                    n_e  = r_e >> 1;
                    n_st = ST_PW_TEST;
                end
            end
            ST_DONE: begin
                if (r_err) n_val = '0;
                n_ovld = 1'b1;
                n_st   = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_ovld <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_ovld <= n_ovld;
            r_go   <= n_go;
        end
        r_act <= n_act;
        r_a   <= n_a;
        r_b   <= n_b;
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_t0  <= n_t0;
        r_t1  <= n_t1;
        r_acc <= n_acc;
        r_e   <= n_e;
        r_val <= n_val;
        r_err <= n_err;
        r_op  <= n_op;
        r_x   <= n_x;
        r_y   <= n_y;
        r_d   <= n_d;
    end

    assign busy          = (r_st != ST_IDLE);
    assign o_valid       = r_ovld;
    assign o_rsp.value   = 31'(r_val);
    assign o_rsp.error   = r_err;

`ifndef ASSERT_OFF
    // a result appears only right after the finishing state
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_st) == ST_DONE) else $error("stray result");
    // an error result carries value zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.error |-> o_rsp.value == '0) else $error("error value");
    // a request is taken only when idle, and makes the unit busy
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("start lost");
`endif

endmodule

// ===== sv/mau_divu.sv =====
// Shared restoring divider: remainder and quotient of a W-bit dividend
// by a divisor, one quotient bit per cycle. For mulmod, the product is
// built instead by shift-and-add, one multiplier bit per cycle, kept reduced.
module mau_divu
    import mau_pkg::*;
#(
    parameter int unsigned W = VALUE_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  t_alu_op      i_op,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_d,
    output logic         o_done,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_quo
);

    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_mul, n_mul;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_sh, n_sh;
    logic [W-1:0]  r_d, n_d;
    logic [W-1:0]  r_x, n_x;
    logic          r_done, n_done;
    logic [W:0]    w_trial;
    logic [W:0]    w_dbl;
    logic [W:0]    w_add;

    // remainder step and modular double/add step
    always_comb begin
        w_trial = {r_rem, r_sh[W-1]} - {1'b0, r_d};
        w_dbl   = {r_rem, 1'b0};
        if (w_dbl >= {1'b0, r_d}) w_dbl = w_dbl - {1'b0, r_d};
        w_add   = w_dbl + {1'b0, r_x};
        if (w_add >= {1'b0, r_d}) w_add = w_add - {1'b0, r_d};
    end

    always_comb begin
        n_busy = r_busy;
        n_mul  = r_mul;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_sh   = r_sh;
        n_d    = r_d;
        n_x    = r_x;
        n_done = 1'b0;
        if (i_go) begin
            // load: for mulmod x must already be below d
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_d    = i_d;
            n_rem  = '0;
            n_quo  = '0;
            n_mul  = (i_op == OP_MULMOD);
            n_sh   = (i_op == OP_MULMOD) ? i_y : i_x;
            n_x    = i_x;
        end else if (r_busy) begin
            if (r_mul) begin
                n_rem = r_sh[W-1] ? w_add[W-1:0] : w_dbl[W-1:0];
            end else if (!w_trial[W]) begin
                n_rem = w_trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[W-2:0], r_sh[W-1]};
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_sh  = {r_sh[W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_mul  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_mul  <= n_mul;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_sh  <= n_sh;
        r_d   <= n_d;
        r_x   <= n_x;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule
